// File: rtl/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types and constants for the full linear convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

    // Result value width, fixed by the output format (Q7.30 scaling, 37 bits).
    localparam int VALUE_W = 37;

    // Input transaction kinds
    localparam logic OP_LOAD   = 1'b0;  // next tap of the set
    localparam logic OP_SAMPLE = 1'b1;  // next sample of the sequence

    // Per-cell control, driven by the top level each cycle.
    typedef struct packed {
        logic shift;    // take the neighbor's sample
        logic clear;    // zero the history sample
        logic tap_we;   // load a new tap into this cell
        logic capture;  // register the product
        logic active;   // cell index is below the tap count
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/flc_in_if.sv
// ----------------------------------------------------------------------------
// flc_in_if
// Input stream: tap loads and samples, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface flc_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;

    modport source (output valid, output op, output sample, output last, input ready);
    modport sink   (input valid, input op, input sample, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/flc_out_if.sv
// ----------------------------------------------------------------------------
// flc_out_if
// Result stream: convolution outputs, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface flc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [flc_pkg::VALUE_W-1:0] value;
    logic                               final_res;
    logic                               error;

    modport source (output valid, output value, output final_res, output error, input ready);
    modport sink   (input valid, input value, input final_res, input error, output ready);
endinterface

`default_nettype wire

// File: rtl/flc_cell.sv
// ----------------------------------------------------------------------------
// flc_cell
// One tap cell: holds a tap and a history sample, passes the sample on,
// registers the masked tap*sample product.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_cell #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  flc_pkg::t_cell_ctl          i_ctl,
    input  wire  signed [SAMPLE_WIDTH-1:0]    i_tap,
    input  wire  signed [SAMPLE_WIDTH-1:0]    i_prev,
    output logic signed [SAMPLE_WIDTH-1:0]    o_hist,
    output logic signed [2*SAMPLE_WIDTH-1:0]  o_prod
);

    logic signed [SAMPLE_WIDTH-1:0]   r_tap;
    logic signed [SAMPLE_WIDTH-1:0]   r_hist;
    logic signed [2*SAMPLE_WIDTH-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctl.clear) begin
            r_hist <= '0;
        end else if (i_ctl.shift) begin
            r_hist <= i_prev;
        end
    end

    // taps and products are payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.tap_we) begin
            r_tap <= i_tap;
        end
        if (i_ctl.capture) begin
            // signed product, kept out of an unsigned select
            if (i_ctl.active) begin
                r_prod <= r_tap * r_hist;
            end else begin
                r_prod <= '0;
            end
        end
    end

    assign o_hist = r_hist;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/flc_sum_tree.sv
// ----------------------------------------------------------------------------
// flc_sum_tree
// Registered binary adder tree over the cell products, each level registered.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_sum_tree #(
    parameter int N_LEAF = 32,  // power of two, at least 2
    parameter int IN_W   = 32,
    parameter int OUT_W  = 37   // wider than IN_W
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire  signed [IN_W-1:0]   i_leaf [N_LEAF],
    output logic signed [OUT_W-1:0]  o_sum
);

    // heap order: node i sums nodes 2i and 2i+1, leaves sit at N_LEAF..2*N_LEAF-1
    logic signed [OUT_W-1:0] r_node [1:N_LEAF-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 1; i < N_LEAF; i++) begin
                if (2 * i >= N_LEAF) begin
                    r_node[i] <= OUT_W'(i_leaf[2*i-N_LEAF]) + OUT_W'(i_leaf[2*i+1-N_LEAF]);
                end else begin
                    r_node[i] <= r_node[2*i] + r_node[2*i+1];
                end
            end
        end
    end

    assign o_sum = r_node[1];

endmodule

`default_nettype wire

// File: rtl/full_linear_convolution.sv
// ----------------------------------------------------------------------------
// full_linear_convolution
// Full linear convolution of a loaded tap set with a streamed sample sequence.
// ----------------------------------------------------------------------------
// Pipeline: a sample transaction passes through the history shift, the cell
//   multipliers, the LVLS = clog2(MAX_TAPS) adder tree levels and the output
//   register; every stage holds while the output register is stalled.
// Throughput: one tap load or one sample per cycle while the output is not
//   stalled; a last sample blocks the input for (tap count - 1) flush steps plus one history clear step.
// Reset: synchronous, active low; clears tap count, flags, history and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module full_linear_convolution #(
    parameter int MAX_TAPS     = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    flc_in_if.sink     i_in,
    flc_out_if.source  o_out
);

    // ---- derived sizes ----------------------------------------------------
    localparam int CW    = $clog2(MAX_TAPS + 1);               // tap count width
    localparam int LVLS  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1; // tree depth
    localparam int NP    = 1 << LVLS;                          // tree leaves
    localparam int PW    = 2 * SAMPLE_WIDTH;                   // product width
    localparam int ACC_W = PW + LVLS;                          // exact sum width
    localparam int VW    = flc_pkg::VALUE_W;

    // Token that rides along with each output step.
    typedef struct packed {
        logic v;
        logic fin;
        logic err;
    } t_tag;

    // ---- control state ----------------------------------------------------
    logic [CW-1:0] r_count;       // taps held
    logic          r_ovf;         // a tap of this set was dropped
    logic          r_closed;      // tap set closed by a last tap
    logic [CW-1:0] r_flush_left;  // zero-feed steps still to run
    logic          r_clr;         // history clear pending after the tail

    t_tag r_iss;                  // step issued, aligned with the history
    t_tag r_tag [0:LVLS];         // aligned with leaves .. tree root

    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_value;
    logic                 r_out_fin;
    logic                 r_out_err;

    // ---- handshake --------------------------------------------------------
    // Whole pipeline advances together; stalls only when the output
    // register holds a result that has not been taken.
    logic w_en, w_busy, w_acc, w_load, w_samp;

    assign w_en   = !r_out_valid || o_out.ready;
    assign w_busy = (r_flush_left != '0) || r_clr;
    assign i_in.ready = w_en && !w_busy;
    assign w_acc  = i_in.valid && i_in.ready;
    assign w_load = w_acc && (i_in.op == flc_pkg::OP_LOAD);
    assign w_samp = w_acc && (i_in.op == flc_pkg::OP_SAMPLE);

    // ---- tap loading ------------------------------------------------------
    // A load after a closed set starts a new set at index zero.
    logic [CW-1:0] w_eff_count;
    logic          w_space;

    assign w_eff_count = r_closed ? '0 : r_count;
    assign w_space     = w_eff_count < CW'(MAX_TAPS);

    // ---- output steps -----------------------------------------------------
    logic                           w_no_taps, w_flush_step, w_shift, w_clear;
    logic signed [SAMPLE_WIDTH-1:0] w_shift_data;
    t_tag                           w_issue;

    assign w_no_taps    = (r_count == '0);
    assign w_flush_step = w_en && (r_flush_left != '0);
    // no taps: no shift, the masked cells give zero
    assign w_shift      = (w_samp && !w_no_taps) || w_flush_step;
    assign w_clear      = (w_load && i_in.last)
                        || (w_samp && i_in.last && w_no_taps)
                        || (w_en && r_clr);
    // tail steps feed zeros into the chain
    assign w_shift_data = w_samp ? i_in.sample : '0;

    always_comb begin
        w_issue.v = w_samp || w_flush_step;
        if (w_samp) begin
            w_issue.fin = i_in.last && (w_no_taps || (r_count == CW'(1)));
            w_issue.err = w_no_taps || r_ovf;
        end else begin
            w_issue.fin = (r_flush_left == CW'(1));
            w_issue.err = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_closed     <= 1'b0;
            r_flush_left <= '0;
            r_clr        <= 1'b0;
            r_iss        <= '0;
            for (int k = 0; k <= LVLS; k++) begin
                r_tag[k] <= '0;
            end
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load) begin
                r_count  <= w_space ? w_eff_count + CW'(1) : w_eff_count;
                r_ovf    <= w_space ? (r_ovf && !r_closed) : 1'b1;
                r_closed <= i_in.last;
            end

            if (w_en && r_clr) begin
                r_clr <= 1'b0;
            end
            // last sample: run the tail, then clear the history
            if (w_samp && i_in.last && !w_no_taps) begin
                if (r_count == CW'(1)) begin
                    r_clr <= 1'b1;
                end else begin
                    r_flush_left <= r_count - CW'(1);
                end
            end
            if (w_flush_step) begin
                r_flush_left <= r_flush_left - CW'(1);
                if (r_flush_left == CW'(1)) begin
                    r_clr <= 1'b1;
                end
            end

            if (w_en) begin
                r_iss    <= w_issue;
                r_tag[0] <= r_iss;
                for (int k = 1; k <= LVLS; k++) begin
                    r_tag[k] <= r_tag[k-1];
                end
                r_out_valid <= r_tag[LVLS].v;
            end
        end
    end

    // ---- cell chain -------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] w_hist [MAX_TAPS];
    logic signed [PW-1:0]           w_prod [MAX_TAPS];
    logic signed [PW-1:0]           w_leaf [NP];
    flc_pkg::t_cell_ctl             w_ctl  [MAX_TAPS];

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        assign w_ctl[j].shift   = w_shift;
        assign w_ctl[j].clear   = w_clear;
        assign w_ctl[j].tap_we  = w_load && w_space && (w_eff_count == CW'(j));
        assign w_ctl[j].capture = w_en;
        assign w_ctl[j].active  = CW'(j) < r_count;

        if (j == 0) begin : g_head
            flc_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[j]),
                .i_tap   (i_in.sample),
                .i_prev  (w_shift_data),
                .o_hist  (w_hist[j]),
                .o_prod  (w_prod[j])
            );
        end else begin : g_body
            flc_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[j]),
                .i_tap   (i_in.sample),
                .i_prev  (w_hist[j-1]),
                .o_hist  (w_hist[j]),
                .o_prod  (w_prod[j])
            );
        end
    end

    // pad the tree to a power of two with zero leaves
    for (genvar j = 0; j < NP; j++) begin : g_leaf
        if (j < MAX_TAPS) begin : g_used
            assign w_leaf[j] = w_prod[j];
        end else begin : g_pad
            assign w_leaf[j] = '0;
        end
    end

    // ---- reduction --------------------------------------------------------
    logic signed [ACC_W-1:0] w_root;
    logic signed [VW-1:0]    w_fit;

    flc_sum_tree #(
        .N_LEAF (NP),
        .IN_W   (PW),
        .OUT_W  (ACC_W)
    ) u_tree (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_leaf (w_leaf),
        .o_sum  (w_root)
    );

    // result field keeps the low bits of the exact sum, or sign-extends a narrower one
    if (ACC_W >= VW) begin : g_trunc
        assign w_fit = w_root[VW-1:0];
    end else begin : g_sext
        assign w_fit = {{(VW-ACC_W){w_root[ACC_W-1]}}, w_root};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_value <= w_fit;
            r_out_fin   <= r_tag[LVLS].fin;
            r_out_err   <= r_tag[LVLS].err;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_out_value;
    assign o_out.final_res = r_out_fin;
    assign o_out.error     = r_out_err;

endmodule

`default_nettype wire

// File: rtl/flc_chk.sv
// ----------------------------------------------------------------------------
// flc_chk
// Port-level checks for the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_chk (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_ready,
    input wire                               i_out_valid,
    input wire                               i_out_ready,
    input wire signed [flc_pkg::VALUE_W-1:0] i_out_value,
    input wire                               i_out_final,
    input wire                               i_out_error
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // reset leaves the input ready
    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // a waiting result stalls the whole pipeline, input included
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while a result is stalled");

    // a stalled result holds its transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_final)
             && $stable(i_out_error)))
        else $error("stalled result changed");

endmodule

bind full_linear_convolution flc_chk u_flc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_final (o_out.final_res),
    .i_out_error (o_out.error)
);

`default_nettype wire
